// ===== sv/ppq_pkg.sv =====
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared types and constants of the preemptive priority task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ppq_pkg;

  localparam int PRIO_W     = 14;
  localparam int HANDLE_W   = 32;
  localparam int STATUS_W   = 3;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [PRIO_W-1:0] IDLE_RESET = 14'd9999;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_FINISH   = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ADDED      = 3'd0,
    STAT_QFULL      = 3'd1,
    STAT_DISPATCHED = 3'd2,
    STAT_NOT_URGENT = 3'd3,
    STAT_EMPTY      = 3'd4,
    STAT_NEST_FULL  = 3'd5,
    STAT_RESTORED   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_CMP,
    ST_ADD_PUT,
    ST_DSP_CHK,
    ST_FIN_LD
  } state_e;

  // One queue entry as stored in memory
  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } queue_entry_t;

  // Configuration update handed from the register block to the core
  typedef struct packed {
    logic              wr;
    logic [PRIO_W-1:0] idle;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/ppq_ram.sv =====
// ----------------------------------------------------------------------------
// ppq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ppq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ppq_apb.sv =====
// ----------------------------------------------------------------------------
// ppq_apb
// APB register block holding the idle priority register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppq_apb
  import ppq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  logic              hit_idle;
  logic              wr_idle;
  logic [PRIO_W-1:0] idle_q;
  logic [PRIO_W-1:0] idle_d;

  // Register 0 sits at byte address 0; the word above it is unmapped
  assign hit_idle = !paddr[2];
  assign wr_idle  = psel && penable && pwrite && hit_idle;
  assign idle_d   = pwdata[PRIO_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= IDLE_RESET;
    end else if (wr_idle) begin
      idle_q <= idle_d;
    end
  end

  // Read data and zero-wait-state ready
  assign prdata = hit_idle ? {{(APB_DATA_W-PRIO_W){1'b0}}, idle_q} : '0;
  assign pready = 1'b1;

  // Hand the new value to the core in the write cycle itself
  assign cfg_o.wr   = wr_idle;
  assign cfg_o.idle = wr_idle ? idle_d : idle_q;

endmodule

`default_nettype wire

// ===== sv/preemptive_priority_task_queue_unit.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_task_queue_unit
// Priority-sorted task queue in a circular RAM with a RAM stack of
// preempted priorities, driven by add / dispatch / finish commands.
// ----------------------------------------------------------------------------
// The result word strobes on done_o in the cycle after the last work cycle.
//   Add to an empty or full queue, dispatch on an empty queue, finish at
//   nesting level zero and the unused command finish in the idle state; any
//   other dispatch and a nested finish add one RAM read; any other add walks
//   from the tail, shifting each queued entry with a larger number one per
//   cycle through the queue RAM.
// Throughput: one word at a time; busy_o drops as the result is registered.
// Reset: queue and stack empty, running priority = idle priority (9999);
//   RAM contents are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_task_queue_unit
  import ppq_pkg::*;
#(
  parameter int  QUEUE_DEPTH = 16,
  parameter int  NEST_DEPTH  = 8,
  localparam int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // command channel
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [1:0]            command_i,
  input  wire logic [PRIO_W-1:0]     task_priority_in_i,
  input  wire logic [HANDLE_W-1:0]   task_handle_in_i,
  // result channel
  output logic                       done_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [HANDLE_W-1:0]        task_handle_out_o,
  output logic [PRIO_W-1:0]          task_priority_out_o,
  output logic [PRIO_W-1:0]          running_priority_o,
  output logic [CW-1:0]              pending_count_o,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int NW  = $clog2(NEST_DEPTH + 1);
  localparam int SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int EW  = PRIO_W + HANDLE_W;

  // Logical queue position to physical RAM address (circular, any depth)
  function automatic logic [QW-1:0] qaddr(input logic [QW-1:0] base,
                                          input logic [QW-1:0] off);
    logic [QW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (QW+1)'(QUEUE_DEPTH)) begin
      s = s - (QW+1)'(QUEUE_DEPTH);
    end
    return s[QW-1:0];
  endfunction

  cfg_t cfg;

  state_e              state_q, state_d;
  cmd_e                cmd_in;
  logic [PRIO_W-1:0]   prio_in_q;
  logic [HANDLE_W-1:0] handle_in_q;
  logic [QW-1:0]       pos_q, pos_d;
  logic [QW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [PRIO_W-1:0]   cur_q, cur_d;
  logic [NW-1:0]       nest_q, nest_d;
  logic [NW-1:0]       nest_dec;
  logic [QW-1:0]       count_lo;
  logic                accept;

  // queue RAM port signals
  logic                q_we, q_re;
  logic [QW-1:0]       q_waddr, q_raddr;
  queue_entry_t        q_wdata, q_rdata, new_entry;
  logic [EW-1:0]       q_rdata_raw;

  // stack RAM port signals
  logic                s_we, s_re;
  logic [SAW-1:0]      s_waddr, s_raddr;
  logic [PRIO_W-1:0]   s_wdata, s_rdata;

  // result word
  logic                res_fire;
  status_e             res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [PRIO_W-1:0]   res_prio;

  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [HANDLE_W-1:0] hout_q;
  logic [PRIO_W-1:0]   pout_q;
  logic [PRIO_W-1:0]   run_q;
  logic [CW-1:0]       pend_q;

  // --------------------------------------------------------------------------
  // Register block and memories
  // --------------------------------------------------------------------------
  ppq_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH),
    .AW    (QW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata_raw)
  );

  assign q_rdata = queue_entry_t'(q_rdata_raw);

  ppq_ram #(
    .WIDTH (PRIO_W),
    .DEPTH (NEST_DEPTH),
    .AW    (SAW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  assign accept    = start_i && (state_q == ST_IDLE);
  assign busy_o    = (state_q != ST_IDLE);
  assign cmd_in    = cmd_e'(command_i);
  assign nest_dec  = nest_q - NW'(1);
  assign count_lo  = count_q[QW-1:0];
  assign new_entry = '{prio: prio_in_q, handle: handle_in_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      cur_q   <= IDLE_RESET;
      nest_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      nest_q  <= nest_d;
    end
  end

  // Latch the command word and walk position
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (accept) begin
      prio_in_q   <= task_priority_in_i;
      handle_in_q <= task_handle_in_i;
    end
  end

  // Next state, RAM accesses and result word
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    head_d     = head_q;
    count_d    = count_q;
    cur_d      = cur_q;
    nest_d     = nest_q;
    q_we       = 1'b0;
    q_waddr    = qaddr(head_q, pos_q);
    q_wdata    = new_entry;
    q_re       = 1'b0;
    q_raddr    = head_q;
    s_we       = 1'b0;
    s_waddr    = nest_q[SAW-1:0];
    s_wdata    = cur_q;
    s_re       = 1'b0;
    s_raddr    = nest_dec[SAW-1:0];
    res_fire   = 1'b0;
    res_status = STAT_NOT_URGENT;
    res_handle = '0;
    res_prio   = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_in)
            CMD_ADD: begin
              if (count_q == CW'(QUEUE_DEPTH)) begin
                res_fire   = 1'b1;
                res_status = STAT_QFULL;
              end else if (count_q == '0) begin
                // empty queue: the new word becomes the head
                q_we       = 1'b1;
                q_waddr    = head_q;
                q_wdata    = '{prio: task_priority_in_i, handle: task_handle_in_i};
                count_d    = count_q + CW'(1);
                res_fire   = 1'b1;
                res_status = STAT_ADDED;
              end else begin
                // start the walk at the tail
                q_re    = 1'b1;
                q_raddr = qaddr(head_q, count_lo - QW'(1));
                pos_d   = count_lo;
                state_d = ST_ADD_CMP;
              end
            end
            CMD_DISPATCH: begin
              if (count_q == '0) begin
                res_fire   = 1'b1;
                res_status = STAT_EMPTY;
              end else begin
                q_re    = 1'b1;
                q_raddr = head_q;
                state_d = ST_DSP_CHK;
              end
            end
            CMD_FINISH: begin
              if (nest_q == '0) begin
                cur_d      = cfg.idle;
                res_fire   = 1'b1;
                res_status = STAT_RESTORED;
              end else begin
                s_re    = 1'b1;
                nest_d  = nest_dec;
                state_d = ST_FIN_LD;
              end
            end
            default: begin
              res_fire   = 1'b1;
              res_status = STAT_NOT_URGENT;
            end
          endcase
        end
      end

      ST_ADD_CMP: begin
        if (q_rdata.prio > prio_in_q) begin
          // shift the larger entry one place toward the tail
          q_we    = 1'b1;
          q_wdata = q_rdata;
          pos_d   = pos_q - QW'(1);
          if (pos_q == QW'(1)) begin
            state_d = ST_ADD_PUT;
          end else begin
            q_re    = 1'b1;
            q_raddr = qaddr(head_q, pos_q - QW'(2));
          end
        end else begin
          // slot found behind all entries of equal or smaller number
          q_we       = 1'b1;
          count_d    = count_q + CW'(1);
          res_fire   = 1'b1;
          res_status = STAT_ADDED;
          state_d    = ST_IDLE;
        end
      end

      ST_ADD_PUT: begin
        q_we       = 1'b1;
        q_waddr    = head_q;
        count_d    = count_q + CW'(1);
        res_fire   = 1'b1;
        res_status = STAT_ADDED;
        state_d    = ST_IDLE;
      end

      ST_DSP_CHK: begin
        res_fire = 1'b1;
        state_d  = ST_IDLE;
        if (cur_q <= q_rdata.prio) begin
          res_status = STAT_NOT_URGENT;
        end else if (nest_q == NW'(NEST_DEPTH)) begin
          res_status = STAT_NEST_FULL;
        end else begin
          // push the running priority, pop the head
          s_we       = 1'b1;
          nest_d     = nest_q + NW'(1);
          cur_d      = q_rdata.prio;
          head_d     = qaddr(head_q, QW'(1));
          count_d    = count_q - CW'(1);
          res_status = STAT_DISPATCHED;
          res_handle = q_rdata.handle;
          res_prio   = q_rdata.prio;
        end
      end

      ST_FIN_LD: begin
        cur_d      = s_rdata;
        res_fire   = 1'b1;
        res_status = STAT_RESTORED;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // idle priority follows the register while nothing is preempted
    if (cfg.wr && (nest_q == '0)) begin
      cur_d = cfg.idle;
    end
  end

  // --------------------------------------------------------------------------
  // Result word register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      status_q <= res_status;
      hout_q   <= res_handle;
      pout_q   <= res_prio;
      run_q    <= cur_d;
      pend_q   <= count_d;
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign task_handle_out_o   = hout_q;
  assign task_priority_out_o = pout_q;
  assign running_priority_o  = run_q;
  assign pending_count_o     = pend_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_nest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nest_q <= NW'(NEST_DEPTH))
    else $error("nesting level beyond stack depth");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted word neither in progress nor finished");

  a_dispatch_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_DISPATCHED)) |->
      (task_priority_out_o == running_priority_o))
    else $error("dispatched priority is not the running one");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STAT_DISPATCHED)) |->
      ((task_handle_out_o == '0) && (task_priority_out_o == '0)))
    else $error("nonzero task fields without dispatch");

endmodule

`default_nettype wire

// ===== tb/preemptive_priority_task_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_task_queue_unit_tb
// Self-checking bench for the preemptive priority task queue. A short table
// of command words covers reset state, field extremes, equal priorities,
// and the empty and not-urgent refusals; then random phases of preemption
// chains, add bursts, drains and noise, each with its own idle priority and
// sender gap rate. Each result word is checked field by field against the
// table row or a behavioral model of the sorted queue and saved priorities.
// ----------------------------------------------------------------------------

module preemptive_priority_task_queue_unit_tb;
  import ppq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 16;
  localparam int NEST_DEPTH  = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [APB_ADDR_W-1:0] IDLE_PRIO_ADDR = '0;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 170;

  // One result word as the block reports it
  typedef struct packed {
    status_e             st;
    logic [HANDLE_W-1:0] hout;
    logic [PRIO_W-1:0]   pout;
    logic [PRIO_W-1:0]   run;
    logic [CNT_W-1:0]    cnt;
  } result_t;

  // One row of the directed table
  typedef struct {
    cmd_e                cmd;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
    bit                  typed;
    result_t             res;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic [1:0]            command_i;
  logic [PRIO_W-1:0]     task_priority_in_i;
  logic [HANDLE_W-1:0]   task_handle_in_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [HANDLE_W-1:0]   task_handle_out_o;
  logic [PRIO_W-1:0]     task_priority_out_o;
  logic [PRIO_W-1:0]     running_priority_o;
  logic [CNT_W-1:0]      pending_count_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Model state: sorted wait queue, saved priorities, running and idle level
  logic [PRIO_W-1:0]   wait_prio[$];
  logic [HANDLE_W-1:0] wait_handle[$];
  logic [PRIO_W-1:0]   saved_run[$];
  logic [PRIO_W-1:0]   run_prio;
  logic [PRIO_W-1:0]   idle_prio;

  result_t   pending_results[$];
  stim_row_t stim_rows[$];
  bit        drive_typed;
  result_t   drive_res;
  int        mismatch_count;
  int        words_sent;
  int        gap_pct;

  preemptive_priority_task_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NEST_DEPTH (NEST_DEPTH)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .command_i          (command_i),
    .task_priority_in_i (task_priority_in_i),
    .task_handle_in_i   (task_handle_in_i),
    .done_o             (done_o),
    .status_o           (status_o),
    .task_handle_out_o  (task_handle_out_o),
    .task_priority_out_o(task_priority_out_o),
    .running_priority_o (running_priority_o),
    .pending_count_o    (pending_count_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Apply one command word to the queue model and return its result word
  function automatic result_t next_result(input cmd_e c, input logic [PRIO_W-1:0] p,
                                          input logic [HANDLE_W-1:0] h);
    result_t r;
    int      pos;
    r = '0;
    case (c)
      CMD_ADD: begin
        if (wait_prio.size() >= QUEUE_DEPTH) begin
          r.st = STAT_QFULL;
        end else begin
          // insert behind every entry of equal or smaller number
          pos = 0;
          while (pos < wait_prio.size() && wait_prio[pos] <= p) pos++;
          wait_prio.insert(pos, p);
          wait_handle.insert(pos, h);
          r.st = STAT_ADDED;
        end
      end
      CMD_DISPATCH: begin
        if (wait_prio.size() == 0) begin
          r.st = STAT_EMPTY;
        end else if (run_prio <= wait_prio[0]) begin
          r.st = STAT_NOT_URGENT;
        end else if (saved_run.size() >= NEST_DEPTH) begin
          r.st = STAT_NEST_FULL;
        end else begin
          r.hout = wait_handle.pop_front();
          r.pout = wait_prio.pop_front();
          saved_run.push_back(run_prio);
          run_prio = r.pout;
          r.st = STAT_DISPATCHED;
        end
      end
      CMD_FINISH: begin
        if (saved_run.size() == 0) run_prio = idle_prio;
        else run_prio = saved_run.pop_back();
        r.st = STAT_RESTORED;
      end
      default: r.st = STAT_NOT_URGENT;
    endcase
    r.run = run_prio;
    r.cnt = CNT_W'(wait_prio.size());
    return r;
  endfunction

  // Check result words, then predict each word accepted at this edge
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t pred;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        got = '{status_e'(status_o), task_handle_out_o, task_priority_out_o,
                running_priority_o, pending_count_o};
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending, status", got.st, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.st !== want.st) report_mismatch("status", got.st, want.st);
          if (got.hout !== want.hout) report_mismatch("task_handle_out", got.hout, want.hout);
          if (got.pout !== want.pout) report_mismatch("task_priority_out", got.pout, want.pout);
          if (got.run !== want.run) report_mismatch("running_priority", got.run, want.run);
          if (got.cnt !== want.cnt) report_mismatch("pending_count", got.cnt, want.cnt);
        end
      end
      if (start_i && !busy_o) begin
        pred = next_result(cmd_e'(command_i), task_priority_in_i, task_handle_in_i);
        pending_results.push_back(drive_typed ? drive_res : pred);
      end
    end
  end

  function automatic void dir_plain(input cmd_e c, input logic [PRIO_W-1:0] p,
                                    input logic [HANDLE_W-1:0] h);
    stim_row_t r;
    r.cmd = c; r.prio = p; r.handle = h; r.typed = 1'b0; r.res = '0;
    stim_rows.push_back(r);
  endfunction

  // Rows whose outcome is plain from the reset state: idle level still runs
  function automatic void dir_typed(input cmd_e c, input logic [PRIO_W-1:0] p,
                                    input logic [HANDLE_W-1:0] h, input status_e st,
                                    input logic [CNT_W-1:0] cnt);
    stim_row_t r;
    r.cmd = c; r.prio = p; r.handle = h; r.typed = 1'b1;
    r.res = '{st, 32'd0, 14'd0, IDLE_RESET, cnt};
    stim_rows.push_back(r);
  endfunction

  function automatic logic [PRIO_W-1:0] rand_prio();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(0, 3))
      0:       p = $urandom_range(0, 1) ? {PRIO_W{1'b1}} : '0;
      1:       p = PRIO_W'($urandom_range(0, 15));
      default: p = PRIO_W'($urandom);
    endcase
    return p;
  endfunction

  // Send one command word; enter and leave at a falling edge
  task automatic issue_word(input cmd_e c, input logic [PRIO_W-1:0] p,
                            input logic [HANDLE_W-1:0] h, input bit typed = 1'b0,
                            input result_t res = '0);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      // idle with junk on the payload
      start_i = 1'b0;
      command_i = 2'($urandom);
      task_priority_in_i = PRIO_W'($urandom);
      task_handle_in_i = $urandom;
      repeat (gap) @(negedge clk_i);
    end
    drive_typed = typed;
    drive_res = res;
    command_i = c;
    task_priority_in_i = p;
    task_handle_in_i = h;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Hold off until every result word is back and the core has gone quiet
  task automatic settle();
    start_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the idle priority, then read it back
  task automatic write_idle_prio(input logic [PRIO_W-1:0] v);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = IDLE_PRIO_ADDR;
    pwdata = {18'($urandom), v};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    idle_prio = v;
    if (saved_run.size() == 0) run_prio = v;
    @(negedge clk_i);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[PRIO_W-1:0] !== v) report_mismatch("idle_priority readback", prdata, v);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Emit one random sequence of command words
  task automatic run_sequence();
    int                kind;
    int                n;
    logic [PRIO_W-1:0] p;
    logic [PRIO_W-1:0] base;
    kind = $urandom_range(0, 9);
    n = $urandom_range(1, 12);
    if (kind < 3) begin
      // preemption chain: queue a more urgent task, then dispatch it
      for (int i = 0; i < n; i++) begin
        if (run_prio != 0 && $urandom_range(0, 7) != 0) begin
          p = run_prio - PRIO_W'($urandom_range(1, (run_prio > 64) ? 64 : run_prio));
          issue_word(CMD_ADD, p, $urandom);
        end
        issue_word(CMD_DISPATCH, rand_prio(), $urandom);
      end
    end else if (kind < 5) begin
      // burst of adds, many at one level to build ties
      base = rand_prio();
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        issue_word(CMD_ADD, $urandom_range(0, 1) ? base : rand_prio(), $urandom);
    end else if (kind < 7) begin
      // drain: dispatch and unwind
      for (int i = 0; i < n; i++)
        issue_word(cmd_e'($urandom_range(0, 1) ? CMD_DISPATCH : CMD_FINISH),
                   rand_prio(), $urandom);
    end else begin
      for (int i = 0; i < n; i++)
        issue_word(cmd_e'($urandom_range(0, 3)), rand_prio(), $urandom);
    end
  endtask

  initial begin
    logic [PRIO_W-1:0] idle_plan[PHASES];
    int                pct_plan[PHASES];
    int                stop_at;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    command_i = '0;
    task_priority_in_i = '0;
    task_handle_in_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    drive_typed = 1'b0;
    drive_res = '0;
    mismatch_count = 0;
    words_sent = 0;
    gap_pct = 0;
    idle_prio = IDLE_RESET;
    run_prio = IDLE_RESET;

    // directed table: reset state, extremes, ties, refusals
    dir_typed(CMD_DISPATCH, 14'd0, 32'd0, STAT_EMPTY, 0);
    dir_typed(CMD_FINISH, 14'd0, 32'd0, STAT_RESTORED, 0);
    dir_typed(CMD_UNUSED, 14'h3FFF, 32'hFFFF_FFFF, STAT_NOT_URGENT, 0);
    dir_typed(CMD_ADD, 14'h3FFF, 32'hFFFF_FFFF, STAT_ADDED, 1);
    dir_typed(CMD_DISPATCH, 14'd0, 32'd0, STAT_NOT_URGENT, 1);
    dir_typed(CMD_ADD, IDLE_RESET, 32'd0, STAT_ADDED, 2);
    dir_typed(CMD_DISPATCH, 14'd0, 32'd0, STAT_NOT_URGENT, 2);
    dir_plain(CMD_ADD, 14'd0, 32'hA5A5_5A5A);
    dir_plain(CMD_ADD, 14'd0, 32'h5A5A_A5A5);
    dir_plain(CMD_DISPATCH, 14'd0, 32'd0);
    dir_plain(CMD_DISPATCH, 14'd0, 32'd0);
    dir_plain(CMD_ADD, 14'd9998, 32'h0000_FFFF);
    dir_plain(CMD_FINISH, 14'd0, 32'd0);
    dir_plain(CMD_DISPATCH, 14'h3FFF, 32'hFFFF_FFFF);
    dir_plain(CMD_DISPATCH, 14'd0, 32'd0);
    dir_plain(CMD_FINISH, 14'd0, 32'd0);
    dir_plain(CMD_DISPATCH, 14'd0, 32'd0);
    dir_plain(CMD_FINISH, 14'd0, 32'd0);
    dir_plain(CMD_FINISH, 14'h3FFF, 32'hFFFF_FFFF);
    dir_plain(CMD_ADD, 14'h3FFF, 32'hFFFF_0000);
    dir_plain(CMD_UNUSED, 14'd0, 32'd0);
    dir_plain(CMD_ADD, 14'd1, 32'h1234_5678);
    dir_plain(CMD_DISPATCH, 14'd0, 32'd0);
    dir_plain(CMD_FINISH, 14'd0, 32'd0);

    // random phases: idle level and sender gap rate per phase
    idle_plan = '{14'h3FFF, 14'd0, PRIO_W'($urandom), 14'd1, IDLE_RESET,
                  PRIO_W'($urandom)};
    pct_plan = '{0, 80, 7, 0, 80, 7};

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i])
      issue_word(stim_rows[i].cmd, stim_rows[i].prio, stim_rows[i].handle,
                 stim_rows[i].typed, stim_rows[i].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      // sometimes unwind first so the write also moves the running level
      if ($urandom_range(0, 1) != 0) begin
        while (saved_run.size() != 0) issue_word(CMD_FINISH, rand_prio(), $urandom);
        settle();
      end
      write_idle_prio(idle_plan[ph]);
      gap_pct = pct_plan[ph];
      stop_at = words_sent + PHASE_WORDS;
      while (words_sent < stop_at) run_sequence();
    end

    settle();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Bound the run in case the block stops answering
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
